### design/dmph_pkg.sv
// ----------------------------------------------------------------------------
// dmph_pkg: shared types and constants for the double-modulus prefix hash
// Holds the two primes, their folding constants, codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dmph_pkg;

    // Primes 2^32-5 and 2^32-17; 2^32 is congruent to the fold constant
    localparam logic [31:0] P_HIGH = 32'hFFFF_FFFB;
    localparam logic [31:0] P_LOW  = 32'hFFFF_FFEF;
    localparam logic [4:0]  C_HIGH = 5'd5;
    localparam logic [4:0]  C_LOW  = 5'd17;

    localparam int          BASE_W     = 31;
    localparam logic [30:0] BASE_RESET = 31'd256;

    // Configuration register indexes
    localparam logic REG_BASE_HIGH = 1'b0;
    localparam logic REG_BASE_LOW  = 1'b1;

    // Commands
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_QREAD,
        S_QLOAD,
        S_MUL,
        S_RED1,
        S_RED2,
        S_RED3,
        S_POST,
        S_WRITE,
        S_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

### design/double_mod_prefix_hash.sv
// ----------------------------------------------------------------------------
// double_mod_prefix_hash: polynomial prefix hash modulo two primes
// Keeps prefix hashes and base powers of a byte string modulo 2^32-5 and
// 2^32-17 and answers substring hash queries, using one shared modular
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  input   | in        | in_valid / in_stall | cmd restart byte_value left right
//  output  | out       | out_valid/out_stall | hash_value status
//  config  | in        | cfg_write           | cfg_index cfg_data
//
//  An append reads its row and forms four products (hash hi, hash lo, power
//  hi, power lo) in the single 32x32 modular multiply-and-fold unit, each via
//  S_MUL, S_RED1, S_RED2, S_RED3 and S_POST, then writes the row; a query reads
//  two rows and forms two products. A full append or a bad range skips to S_FINISH.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a stalled output holds the block in its final state.
//  Reset (rst_n, asynchronous) empties the string and sets both bases to 256.
//  Table entry 0 is a constant and needs no clearing pass.
//
`default_nettype none

module double_mod_prefix_hash #(
    parameter int MAX_LEN = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         cmd,
    input  wire logic                         restart,
    input  wire logic [7:0]                   byte_value,
    input  wire logic [12:0]                  left,
    input  wire logic [12:0]                  right,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [63:0]                       hash_value,
    output logic [1:0]                        status,
    // configuration
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [dmph_pkg::BASE_W-1:0]  cfg_data
);
    import dmph_pkg::*;

    // table address width, also wide enough for the length
    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int CW = (AW > 13) ? AW : 13;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [63:0] hash_mem [0:MAX_LEN];
    logic [63:0] pow_mem  [0:MAX_LEN];

    logic [63:0] hash_q_reg;
    logic [63:0] pow_q_reg;
    logic        hash_zero_reg;
    logic        pow_zero_reg;
    logic [AW-1:0] hash_raddr;
    logic [AW-1:0] pow_raddr;
    logic [AW-1:0] waddr;
    logic        mem_we;
    logic [63:0] hash_rd;
    logic [63:0] pow_rd;

    // control state
    seq_state_t  state_reg, state_next;
    logic [1:0]  step_reg;
    logic [AW-1:0] length_reg;
    logic [BASE_W-1:0] base_high_reg;
    logic [BASE_W-1:0] base_low_reg;
    logic        out_valid_reg;

    // transaction payload held while the sequencer runs
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic [12:0] left_reg;
    logic [AW-1:0] n_reg;
    logic [63:0] hrow_reg;
    logic [63:0] prow_reg;
    logic [63:0] hright_reg;
    logic [63:0] prod_reg;
    logic [37:0] t1_reg;
    logic [32:0] t2_reg;
    logic [31:0] red_reg;
    logic [31:0] res_reg [0:3];
    logic [1:0]  st_reg;
    logic [63:0] hash_value_reg;
    logic [1:0]  status_reg;

    // combinational helpers
    logic        in_take;
    logic        out_load;
    logic [AW-1:0] n_eff;
    logic        is_full;
    logic        bad_range;
    logic        last_step;
    logic [31:0] mod_p;
    logic [4:0]  fold_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] hr_half;
    logic [32:0] sum33;
    logic [31:0] add_res;
    logic [31:0] sub_res;
    logic [31:0] post_res;

    // ------------------------------------------------------------------
    // Handshake and decode
    // ------------------------------------------------------------------
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign n_eff     = restart ? '0 : length_reg;
    // full check on the held row index
    assign is_full   = (n_reg == AW'(MAX_LEN));
    // valid range is left <= right <= length
    assign bad_range = (left > right) || (CW'(right) > CW'(length_reg));
    assign last_step = (cmd_reg == CMD_QUERY) ? (step_reg == 2'd1) : (step_reg == 2'd3);

    // entry 0 is constant: hash (0,0), power (1,1)
    assign hash_rd = hash_zero_reg ? 64'd0 : hash_q_reg;
    assign pow_rd  = pow_zero_reg  ? {32'd1, 32'd1} : pow_q_reg;

    // ------------------------------------------------------------------
    // Table addresses: append reads row n, query reads right then left
    // ------------------------------------------------------------------
    always_comb
    begin
        hash_raddr = AW'(right);
        pow_raddr  = AW'(right - left);
        if (state_reg == S_IDLE)
        begin
            if (cmd == CMD_APPEND)
            begin
                hash_raddr = n_eff;
                pow_raddr  = n_eff;
            end
        end
        else
        begin
            hash_raddr = AW'(left_reg);
        end
    end

    assign waddr  = n_reg + 1'b1;
    assign mem_we = (state_reg == S_WRITE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hash_mem[waddr] <= {res_reg[0], res_reg[1]};
            pow_mem[waddr]  <= {res_reg[2], res_reg[3]};
        end
        hash_q_reg    <= hash_mem[hash_raddr];
        pow_q_reg     <= pow_mem[pow_raddr];
        hash_zero_reg <= (hash_raddr == '0);
        pow_zero_reg  <= (pow_raddr == '0);
    end

    // ------------------------------------------------------------------
    // Shared modular multiplier operands
    // Even steps work modulo the high prime, odd steps modulo the low one.
    // Append: hash hi, hash lo, power hi, power lo, each times its base.
    // Query: left hash times span power, hi then lo.
    // ------------------------------------------------------------------
    always_comb
    begin
        mod_p  = step_reg[0] ? P_LOW : P_HIGH;
        fold_c = step_reg[0] ? C_LOW : C_HIGH;
        if (step_reg[1])
            mul_a = step_reg[0] ? prow_reg[31:0] : prow_reg[63:32];
        else
            mul_a = step_reg[0] ? hrow_reg[31:0] : hrow_reg[63:32];
        if (cmd_reg == CMD_QUERY)
            mul_b = step_reg[0] ? prow_reg[31:0] : prow_reg[63:32];
        else
            mul_b = step_reg[0] ? {1'b0, base_low_reg} : {1'b0, base_high_reg};
    end

    // final touch on each reduced product
    always_comb
    begin
        hr_half = step_reg[0] ? hright_reg[31:0] : hright_reg[63:32];
        sum33   = {1'b0, red_reg} + 33'(byte_reg);
        add_res = (sum33 >= {1'b0, mod_p}) ? 32'(sum33 - {1'b0, mod_p}) : sum33[31:0];
        sub_res = (hr_half >= red_reg) ? (hr_half - red_reg)
                                       : (hr_half - red_reg + mod_p);
        if (cmd_reg == CMD_QUERY)
            post_res = sub_res;
        else if (!step_reg[1])
            post_res = add_res;
        else
            post_res = red_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_APPEND)
                        state_next = S_LOAD;
                    else if (bad_range)
                        state_next = S_FINISH;
                    else
                        state_next = S_QREAD;
                end
            end
            S_LOAD:   state_next = is_full ? S_FINISH : S_MUL;
            S_QREAD:  state_next = S_QLOAD;
            S_QLOAD:  state_next = S_MUL;
            S_MUL:    state_next = S_RED1;
            S_RED1:   state_next = S_RED2;
            S_RED2:   state_next = S_RED3;
            S_RED3:   state_next = S_POST;
            S_POST:
            begin
                if (!last_step)
                    state_next = S_MUL;
                else if (cmd_reg == CMD_APPEND)
                    state_next = S_WRITE;
                else
                    state_next = S_FINISH;
            end
            S_WRITE:  state_next = S_FINISH;
            S_FINISH: state_next = out_load ? S_IDLE : S_FINISH;
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        out_valid  = out_valid_reg;
        hash_value = hash_value_reg;
        status     = status_reg;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            length_reg    <= '0;
            base_high_reg <= BASE_RESET;
            base_low_reg  <= BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == REG_BASE_HIGH)
                    base_high_reg <= cfg_data;
                else
                    base_low_reg <= cfg_data;
            end
            // restart empties the string before the byte is handled
            if (in_take && (cmd == CMD_APPEND))
                length_reg <= n_eff;
            if (mem_we)
                length_reg <= waddr;
            if (state_reg == S_IDLE)
                step_reg <= 2'd0;
            else if (state_reg == S_POST)
                step_reg <= step_reg + 2'd1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= cmd;
            byte_reg <= byte_value;
            left_reg <= left;
            n_reg    <= n_eff;
            st_reg   <= ST_OK;
            if ((cmd == CMD_QUERY) && bad_range)
            begin
                res_reg[0] <= 32'd0;
                res_reg[1] <= 32'd0;
                st_reg     <= ST_BAD_RANGE;
            end
        end
        case (state_reg)
            S_LOAD:
            begin
                hrow_reg <= hash_rd;
                prow_reg <= pow_rd;
                // full string: drop the byte and report the whole hash
                if (is_full)
                begin
                    res_reg[0] <= hash_rd[63:32];
                    res_reg[1] <= hash_rd[31:0];
                    st_reg     <= ST_FULL;
                end
            end
            S_QREAD:
            begin
                hright_reg <= hash_rd;
                prow_reg   <= pow_rd;
            end
            S_QLOAD:  hrow_reg <= hash_rd;
            S_MUL:    prod_reg <= 64'(mul_a) * 64'(mul_b);
            // fold the upper word twice, then one conditional subtract
            S_RED1:   t1_reg <= {6'd0, prod_reg[31:0]}
                                + 38'(prod_reg[63:32]) * 38'(fold_c);
            S_RED2:   t2_reg <= {1'b0, t1_reg[31:0]}
                                + 33'(t1_reg[37:32]) * 33'(fold_c);
            S_RED3:   red_reg <= (t2_reg >= {1'b0, mod_p})
                                 ? 32'(t2_reg - {1'b0, mod_p}) : t2_reg[31:0];
            S_POST:   res_reg[step_reg] <= post_res;
            default:  ;
        endcase
        if (out_load)
        begin
            hash_value_reg <= {res_reg[0], res_reg[1]};
            status_reg     <= st_reg;
        end
    end

endmodule

`default_nettype wire

### sim/dmph_checker.sv
// ----------------------------------------------------------------------------
// dmph_checker: result checker for the double-modulus prefix hash
// Watches both channels, keeps its own copy of the hash and power tables,
// works out each expected result and compares it with the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module dmph_checker
    import dmph_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                cmd,
    input  wire logic                restart,
    input  wire logic [7:0]          byte_value,
    input  wire logic [12:0]         left,
    input  wire logic [12:0]         right,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [63:0]         hash_value,
    input  wire logic [1:0]          status,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [BASE_W-1:0]   cfg_data,
    output int                       fail_count,
    output int                       pending_results
);

    typedef struct packed {
        logic [63:0] hash_value;
        logic [1:0]  status;
    } hash_result_t;

    logic [31:0]  base_hi_q, base_lo_q;
    logic [31:0]  hash_hi_tab [0:MAX_LEN];
    logic [31:0]  hash_lo_tab [0:MAX_LEN];
    logic [31:0]  pow_hi_tab  [0:MAX_LEN];
    logic [31:0]  pow_lo_tab  [0:MAX_LEN];
    int unsigned  str_len;
    hash_result_t expected_hashes [$];

    function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] p);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return 32'(prod % 64'(p));
    endfunction

    function automatic logic [31:0] addmod(logic [31:0] a, logic [31:0] b, logic [31:0] p);
        logic [32:0] s;
        s = 33'(a) + 33'(b);
        return 32'(s % 33'(p));
    endfunction

    function automatic logic [31:0] submod(logic [31:0] a, logic [31:0] b, logic [31:0] p);
        logic [32:0] x, y;
        x = 33'(a) % 33'(p);
        y = 33'(b) % 33'(p);
        return (x >= y) ? 32'(x - y) : 32'(x + 33'(p) - y);
    endfunction

    // Advance the string tables on an append and work out each transaction's result
    function automatic hash_result_t predict_hash();
        hash_result_t r;
        int unsigned  n, span;
        logic [31:0]  hi, lo;
        if (cmd == CMD_APPEND) begin
            if (restart)
                str_len = 0;
            n = str_len;
            if (n >= MAX_LEN) begin
                r.hash_value = {hash_hi_tab[MAX_LEN], hash_lo_tab[MAX_LEN]};
                r.status     = ST_FULL;
                return r;
            end
            hash_hi_tab[n+1] = addmod(mulmod(hash_hi_tab[n], base_hi_q, P_HIGH),
                                      32'(byte_value), P_HIGH);
            hash_lo_tab[n+1] = addmod(mulmod(hash_lo_tab[n], base_lo_q, P_LOW),
                                      32'(byte_value), P_LOW);
            pow_hi_tab[n+1]  = mulmod(pow_hi_tab[n], base_hi_q, P_HIGH);
            pow_lo_tab[n+1]  = mulmod(pow_lo_tab[n], base_lo_q, P_LOW);
            str_len = n + 1;
            r.hash_value = {hash_hi_tab[n+1], hash_lo_tab[n+1]};
            r.status     = ST_OK;
            return r;
        end
        if (left > right || right > str_len) begin
            r.hash_value = '0;
            r.status     = ST_BAD_RANGE;
            return r;
        end
        span = right - left;
        hi = submod(hash_hi_tab[right],
                    mulmod(hash_hi_tab[left], pow_hi_tab[span], P_HIGH), P_HIGH);
        lo = submod(hash_lo_tab[right],
                    mulmod(hash_lo_tab[left], pow_lo_tab[span], P_LOW), P_LOW);
        r.hash_value = {hi, lo};
        r.status     = ST_OK;
        return r;
    endfunction

    assign pending_results = expected_hashes.size();

    always @(posedge clk or negedge rst_n)
    begin
        hash_result_t exp_r;
        if (!rst_n) begin
            base_hi_q      = 32'(BASE_RESET);
            base_lo_q      = 32'(BASE_RESET);
            hash_hi_tab[0] = '0;
            hash_lo_tab[0] = '0;
            pow_hi_tab[0]  = 32'd1;
            pow_lo_tab[0]  = 32'd1;
            str_len        = 0;
            fail_count     = 0;
            expected_hashes.delete();
        end else begin
            if (cfg_write) begin
                if (cfg_index == REG_BASE_HIGH)
                    base_hi_q = 32'(cfg_data);
                else
                    base_lo_q = 32'(cfg_data);
            end
            if (in_valid && !in_stall)
                expected_hashes.push_back(predict_hash());
            if (out_valid && !out_stall) begin
                if (expected_hashes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hash %h status %0d",
                                 hash_value, status);
                end else begin
                    exp_r = expected_hashes.pop_front();
                    if (exp_r.hash_value !== hash_value || exp_r.status !== status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected hash %h status %0d, got hash %h status %0d",
                                     exp_r.hash_value, exp_r.status, hash_value, status);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### sim/tb_double_mod_prefix_hash.sv
// ----------------------------------------------------------------------------
// tb_double_mod_prefix_hash: testbench top for the double-modulus prefix hash
// Drives appends and substring queries with random gaps and output stalls,
// rewrites both bases between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_double_mod_prefix_hash;
    import dmph_pkg::*;

    localparam int MAX_LEN    = 4096;
    localparam int IDLE_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_APPEND;
    logic              restart = 1'b0;
    logic [7:0]        byte_value = '0;
    logic [12:0]       left = '0;
    logic [12:0]       right = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [63:0]       hash_value;
    logic [1:0]        status;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_BASE_HIGH;
    logic [BASE_W-1:0] cfg_data = '0;
    int                fail_count;
    int                pending_results;
    int                idle_cycles = 0;
    int unsigned       str_len_model = 0;   // string length as seen by stimulus
    bit                stall_quiet = 1'b0;  // phase with no output stalls

    always #5 clk = ~clk;

    double_mod_prefix_hash #(.MAX_LEN(MAX_LEN)) u_dut (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .restart, .byte_value, .left, .right,
        .out_valid, .out_stall, .hash_value, .status, .cfg_write, .cfg_index, .cfg_data
    );

    dmph_checker #(.MAX_LEN(MAX_LEN)) u_checker (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .restart, .byte_value, .left, .right,
        .out_valid, .out_stall, .hash_value, .status, .cfg_write, .cfg_index, .cfg_data,
        .fail_count, .pending_results
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Output back-pressure: stretches of random stalls, quiet in some phases
    always @(posedge clk)
    begin
        if (stall_quiet)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 29) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 3) != 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one transaction and hold it until accepted, then drop valid.
    // The block stalls after each acceptance, so the extra edge before
    // driving costs nothing.
    task automatic send_item(logic c, logic rs, logic [7:0] b, logic [12:0] l,
                             logic [12:0] r, bit keep_gap);
        int gap;
        gap = keep_gap ? pick_gap() : 0;
        repeat (gap + 1) @(posedge clk);
        in_valid   <= 1'b1;
        cmd        <= c;
        restart    <= rs;
        byte_value <= b;
        left       <= l;
        right      <= r;
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
        if (c == CMD_APPEND) begin
            if (rs)
                str_len_model = 0;
            if (str_len_model < MAX_LEN)
                str_len_model++;
        end
    endtask

    task automatic append_byte(logic rs, logic [7:0] b, bit keep_gap);
        send_item(CMD_APPEND, rs, b, 13'($urandom), 13'($urandom), keep_gap);
    endtask

    task automatic query_range(logic [12:0] l, logic [12:0] r, bit keep_gap);
        send_item(CMD_QUERY, 1'($urandom), 8'($urandom), l, r, keep_gap);
    endtask

    // Wait for every result, plus the block's longest latency, then write bases
    task automatic set_bases(logic [BASE_W-1:0] hi, logic [BASE_W-1:0] lo);
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_BASE_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_BASE_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random query: mostly valid ranges, sometimes broken ones
    task automatic random_query();
        int unsigned l, r;
        case ($urandom_range(0, 9))
            0: begin l = $urandom_range(0, 8191); r = $urandom_range(0, 8191); end
            1: begin r = $urandom_range(0, str_len_model); l = r; end
            2: begin
                   l = $urandom_range(0, str_len_model);
                   r = str_len_model + $urandom_range(1, 50);
               end
            3: begin
                   r = $urandom_range(0, str_len_model);
                   l = (r < 8191) ? r + $urandom_range(1, 20) : r;
                   if (l > 8191) l = 8191;
               end
            default: begin
                r = $urandom_range(0, str_len_model);
                l = $urandom_range(0, r);
            end
        endcase
        query_range(13'(l), 13'(r), 1'b1);
    endtask

    task automatic random_phase(int n_items, int restart_pct);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 55)
                append_byte(($urandom_range(0, 99) < restart_pct), 8'($urandom), 1'b1);
            else
                random_query();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset bases, byte extremes, empty and bad queries
        query_range(13'd0, 13'd0, 1'b0);
        query_range(13'd0, 13'd1, 1'b0);
        append_byte(1'b0, 8'h00, 1'b0);
        append_byte(1'b0, 8'hFF, 1'b0);
        append_byte(1'b0, 8'h80, 1'b0);
        append_byte(1'b0, 8'h7F, 1'b0);
        query_range(13'd0, 13'd4, 1'b0);
        query_range(13'd1, 13'd3, 1'b0);
        query_range(13'd2, 13'd2, 1'b0);
        query_range(13'd3, 13'd1, 1'b0);
        query_range(13'd0, 13'd5, 1'b0);
        query_range(13'h1FFF, 13'h1FFF, 1'b0);
        append_byte(1'b1, 8'hAA, 1'b0);
        append_byte(1'b0, 8'h55, 1'b0);
        query_range(13'd0, 13'd2, 1'b0);
        query_range(13'd1, 13'd4, 1'b0);

        // Largest bases, then a base change part-way through a string
        set_bases(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(150, 3);
        set_bases(31'd0, 31'd1);
        random_phase(100, 5);
        set_bases(31'($urandom), 31'($urandom));
        stall_quiet = 1'b1;
        random_phase(150, 2);
        stall_quiet = 1'b0;

        // Fresh string, then ranges reaching past its end
        set_bases(31'd256, 31'h4000_0001);
        append_byte(1'b1, 8'($urandom), 1'b0);
        query_range(13'd0, 13'd4096, 1'b0);
        query_range(13'd4095, 13'd4096, 1'b0);
        query_range(13'd0, 13'd4097, 1'b0);
        repeat (40) random_query();
        append_byte(1'b1, 8'h01, 1'b0);

        set_bases(31'($urandom), 31'($urandom));
        random_phase(990, 4);

        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### double_mod_prefix_hash.f
design/dmph_pkg.sv
design/double_mod_prefix_hash.sv
sim/dmph_checker.sv
sim/tb_double_mod_prefix_hash.sv
